[rtl/mmu_pkg.sv]
// Shared types and constants for the matrix multiply unit.
package mmu_pkg;

	localparam int MAX_DIM_DEF = 8;
	localparam int VAL_W       = 16;
	localparam int PROD_W      = 2 * VAL_W;
	localparam int SUM_W       = 35;
	localparam int IDX_W       = 3;
	localparam int DIM_W       = 4;
	localparam int CFG_IDX_W   = 2;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

	typedef enum logic [1:0] {
		CMD_WRITE_A = 2'd0,
		CMD_WRITE_B = 2'd1,
		CMD_START   = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_A    = 2'd0,
		REG_INNER_DIM = 2'd1,
		REG_COLS_B    = 2'd2
	} reg_idx_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} state_t;

	typedef struct packed {
		logic             first;
		logic             fin;
		logic             last_elem;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} tag_t;

endpackage

[rtl/mmu_datapath.sv]
// Element stores and multiply-accumulate pipeline of the matrix multiply unit.
module mmu_datapath #(
	parameter int MAX_DIM = mmu_pkg::MAX_DIM_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        adv,
	input  logic                                        wr_a_en,
	input  logic                                        wr_b_en,
	input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]          wr_addr,
	input  logic signed [mmu_pkg::VAL_W-1:0]            wr_data,
	input  logic                                        rd_en,
	input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]          rd_a_addr,
	input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]          rd_b_addr,
	input  mmu_pkg::tag_t                               tag_in,
	output logic                                        res_valid,
	output mmu_pkg::tag_t                               res_tag,
	output logic signed [mmu_pkg::SUM_W-1:0]            res_value
);
	import mmu_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;

	logic signed [VAL_W-1:0]  left_mem  [DEPTH];
	logic signed [VAL_W-1:0]  right_mem [DEPTH];

	logic                     v_s1;
	tag_t                     tag_s1;
	logic signed [VAL_W-1:0]  a_s1;
	logic signed [VAL_W-1:0]  b_s1;
	logic                     v_s2;
	tag_t                     tag_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  sum;

	always_ff @(posedge clk) begin
		if (wr_a_en) begin
			left_mem[wr_addr] <= wr_data;
		end
		if (wr_b_en) begin
			right_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && rd_en) begin
			a_s1 <= left_mem[rd_a_addr];
			b_s1 <= right_mem[rd_b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1  <= tag_in;
			tag_s2  <= tag_s1;
			prod_s2 <= a_s1 * b_s1;
		end
	end

	assign sum = (tag_s2.first ? SUM_W'(0) : acc_q) + SUM_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			acc_q <= sum;
		end
	end

	assign res_valid = v_s2 && tag_s2.fin;
	assign res_tag   = tag_s2;
	assign res_value = sum;

endmodule

[rtl/matrix_multiply_unit.sv]
// Top level of the matrix multiply unit: registers, sequencer and output word register.
//
// Usage: load elements of A (cmd write A) and B (cmd write B) one word per cycle
// on the input channel at (row, col); indices at or beyond MAX_DIM are dropped.
// Set rows_a, inner_dim and cols_b through the configuration channel (index 0..2,
// values above MAX_DIM act as MAX_DIM). A start word emits rows*cols product words
// in row-major order on the output channel, last set on the final one; a zero
// dimension yields no words.
// Throughput: one load per cycle while idle. Each product element is summed by
// the single multiply-accumulate, which reads one entry from each store per cycle
// while the output is not stalled; each word then passes the read registers, the
// product register and the output word register after its last term issues.
// The input channel is held off while a product is being issued.
// A receiver stall freezes the whole read/multiply/accumulate pipeline until the
// waiting output word is taken; nothing is lost.
// Reset clears control state and sets all three dimensions to 8; store contents
// are undefined until written.
module matrix_multiply_unit #(
	parameter int MAX_DIM = mmu_pkg::MAX_DIM_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mmu_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mmu_pkg::DIM_W-1:0]             cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            cmd,
	input  logic [mmu_pkg::IDX_W-1:0]             row,
	input  logic [mmu_pkg::IDX_W-1:0]             col,
	input  logic signed [mmu_pkg::VAL_W-1:0]      value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [mmu_pkg::IDX_W-1:0]             out_row,
	output logic [mmu_pkg::IDX_W-1:0]             out_col,
	output logic signed [mmu_pkg::SUM_W-1:0]      out_value,
	output logic                                  last
);
	import mmu_pkg::*;

	localparam int AW = $clog2(MAX_DIM * MAX_DIM);
	localparam int IW = $clog2(MAX_DIM);
	localparam int CW = $clog2(MAX_DIM + 1);

	logic [DIM_W-1:0]        rows_a_q;
	logic [DIM_W-1:0]        inner_dim_q;
	logic [DIM_W-1:0]        cols_b_q;
	logic [CW-1:0]           nr;
	logic [CW-1:0]           nk;
	logic [CW-1:0]           nc;
	logic                    dims_zero;

	state_t                  state_q;
	state_t                  state_d;
	logic [IW-1:0]           i_q;
	logic [IW-1:0]           j_q;
	logic [IW-1:0]           k_q;
	logic [IW-1:0]           i_d;
	logic [IW-1:0]           j_d;
	logic [IW-1:0]           k_d;
	logic                    issue;
	logic                    k_end;
	logic                    j_end;
	logic                    i_end;
	tag_t                    tag;

	logic                    adv;
	logic                    in_acc;
	logic                    wr_ok;
	logic                    wr_a_en;
	logic                    wr_b_en;
	logic [AW-1:0]           wr_addr;
	logic [AW-1:0]           rd_a_addr;
	logic [AW-1:0]           rd_b_addr;

	logic                    res_valid;
	tag_t                    res_tag;
	logic signed [SUM_W-1:0] res_value;

	logic                    out_valid_q;
	logic [IDX_W-1:0]        out_row_q;
	logic [IDX_W-1:0]        out_col_q;
	logic signed [SUM_W-1:0] out_value_q;
	logic                    last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_RESET;
			inner_dim_q <= DIM_RESET;
			cols_b_q    <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROWS_A:    rows_a_q    <= cfg_data;
				REG_INNER_DIM: inner_dim_q <= cfg_data;
				REG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign nr = (int'(rows_a_q)    > MAX_DIM) ? CW'(MAX_DIM) : CW'(rows_a_q);
	assign nk = (int'(inner_dim_q) > MAX_DIM) ? CW'(MAX_DIM) : CW'(inner_dim_q);
	assign nc = (int'(cols_b_q)    > MAX_DIM) ? CW'(MAX_DIM) : CW'(cols_b_q);
	assign dims_zero = (nr == '0) || (nk == '0) || (nc == '0);

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign adv      = !out_valid_q || out_ready;

	assign wr_ok   = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
	assign wr_a_en = in_acc && wr_ok && (cmd == CMD_WRITE_A);
	assign wr_b_en = in_acc && wr_ok && (cmd == CMD_WRITE_B);
	assign wr_addr = AW'(row) * AW'(MAX_DIM) + AW'(col);

	assign k_end = (CW'(k_q) == nk - CW'(1));
	assign j_end = (CW'(j_q) == nc - CW'(1));
	assign i_end = (CW'(i_q) == nr - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		issue   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && cmd == CMD_START) begin
					state_d = ST_RUN;
					i_d     = '0;
					j_d     = '0;
					k_d     = '0;
				end
			end
			ST_RUN: begin
				if (dims_zero) begin
					state_d = ST_IDLE;
				end else if (adv) begin
					issue = 1'b1;
					if (!k_end) begin
						k_d = k_q + IW'(1);
					end else begin
						k_d = '0;
						if (!j_end) begin
							j_d = j_q + IW'(1);
						end else begin
							j_d = '0;
							if (i_end) begin
								state_d = ST_IDLE;
							end else begin
								i_d = i_q + IW'(1);
							end
						end
					end
				end
			end
		endcase
	end

	assign tag.first     = (k_q == '0);
	assign tag.fin       = k_end;
	assign tag.last_elem = k_end && j_end && i_end;
	assign tag.row       = IDX_W'(i_q);
	assign tag.col       = IDX_W'(j_q);

	assign rd_a_addr = AW'(i_q) * AW'(MAX_DIM) + AW'(k_q);
	assign rd_b_addr = AW'(k_q) * AW'(MAX_DIM) + AW'(j_q);

	mmu_datapath #(
		.MAX_DIM(MAX_DIM)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.wr_a_en   (wr_a_en),
		.wr_b_en   (wr_b_en),
		.wr_addr   (wr_addr),
		.wr_data   (value),
		.rd_en     (issue),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.tag_in    (tag),
		.res_valid (res_valid),
		.res_tag   (res_tag),
		.res_value (res_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_row_q   <= res_tag.row;
			out_col_q   <= res_tag.col;
			out_value_q <= res_value;
			last_q      <= res_tag.last_elem;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;
	assign last      = last_q;

endmodule

[rtl/mmu_checker.sv]
// Port-level assertions for the matrix multiply unit and their bind.
module mmu_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [1:0]                       cmd,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [mmu_pkg::IDX_W-1:0]        out_row,
	input logic [mmu_pkg::IDX_W-1:0]        out_col,
	input logic signed [mmu_pkg::SUM_W-1:0] out_value,
	input logic                             last
);
	import mmu_pkg::*;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && cmd == CMD_START) |=> !in_ready)
		else $error("input ready right after start word");

	a_write_one: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (cmd == CMD_WRITE_A || cmd == CMD_WRITE_B)) |=> in_ready)
		else $error("store write did not complete in one cycle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_row)
			&& $stable(out_col) && $stable(last)))
		else $error("stalled output word changed");

endmodule

bind matrix_multiply_unit mmu_checker u_mmu_checker (.*);

[tb/matrix_multiply_unit_tb.sv]
// Self-checking testbench for the matrix multiply unit: matrix loads, products, dimension settings.
module matrix_multiply_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mmu_pkg::*;

	localparam int DIM = MAX_DIM_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_WORDS = 150;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int MAX_SHOWN = 10;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [SUM_W-1:0] value;
		logic             last;
	} elem_t;

	typedef struct packed {
		logic             is_reg;
		logic [1:0]       code;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
		logic             typed;
		logic [SUM_W-1:0] typed_value;
	} step_t;

	localparam step_t DIRECTED [31] = '{
		'{1'b1, REG_ROWS_A,    3'd0, 3'd0, 16'd1,      1'b0, 35'd0},
		'{1'b1, REG_INNER_DIM, 3'd0, 3'd0, 16'd1,      1'b0, 35'd0},
		'{1'b1, REG_COLS_B,    3'd0, 3'd0, 16'd1,      1'b0, 35'd0},
		'{1'b0, CMD_WRITE_A,   3'd0, 3'd0, 16'h8000,   1'b0, 35'd0},
		'{1'b0, CMD_WRITE_B,   3'd0, 3'd0, 16'h8000,   1'b0, 35'd0},
		'{1'b0, CMD_START,     3'd0, 3'd0, 16'h0000,   1'b1, 35'h0_4000_0000},
		'{1'b0, CMD_WRITE_A,   3'd0, 3'd0, 16'h7fff,   1'b0, 35'd0},
		'{1'b0, CMD_START,     3'd0, 3'd0, 16'h0000,   1'b1, -35'sd1073709056},
		'{1'b0, CMD_WRITE_B,   3'd0, 3'd0, 16'h7fff,   1'b0, 35'd0},
		'{1'b0, CMD_START,     3'd0, 3'd0, 16'h0000,   1'b1, 35'd1073676289},
		'{1'b0, CMD_UNUSED,    3'd7, 3'd7, 16'hffff,   1'b0, 35'd0},
		'{1'b0, CMD_WRITE_A,   3'd7, 3'd7, 16'h5555,   1'b0, 35'd0},
		'{1'b0, CMD_WRITE_B,   3'd7, 3'd7, 16'haaaa,   1'b0, 35'd0},
		'{1'b0, CMD_WRITE_A,   3'd0, 3'd0, 16'h0000,   1'b0, 35'd0},
		'{1'b0, CMD_START,     3'd7, 3'd7, 16'hffff,   1'b1, 35'd0},
		'{1'b1, REG_UNUSED,    3'd0, 3'd0, 16'd0,      1'b0, 35'd0},
		'{1'b1, REG_ROWS_A,    3'd0, 3'd0, 16'd0,      1'b0, 35'd0},
		'{1'b0, CMD_START,     3'd0, 3'd0, 16'h0000,   1'b0, 35'd0},
		'{1'b1, REG_ROWS_A,    3'd0, 3'd0, 16'd15,     1'b0, 35'd0},
		'{1'b1, REG_COLS_B,    3'd0, 3'd0, 16'd0,      1'b0, 35'd0},
		'{1'b0, CMD_START,     3'd0, 3'd0, 16'h0000,   1'b0, 35'd0},
		'{1'b1, REG_COLS_B,    3'd0, 3'd0, 16'd1,      1'b0, 35'd0},
		'{1'b0, CMD_START,     3'd0, 3'd0, 16'h0000,   1'b0, 35'd0},
		'{1'b1, REG_ROWS_A,    3'd0, 3'd0, 16'd1,      1'b0, 35'd0},
		'{1'b1, REG_INNER_DIM, 3'd0, 3'd0, 16'd0,      1'b0, 35'd0},
		'{1'b0, CMD_START,     3'd0, 3'd0, 16'h0000,   1'b0, 35'd0},
		'{1'b1, REG_INNER_DIM, 3'd0, 3'd0, 16'd15,     1'b0, 35'd0},
		'{1'b0, CMD_START,     3'd0, 3'd0, 16'h0000,   1'b0, 35'd0},
		'{1'b1, REG_INNER_DIM, 3'd0, 3'd0, 16'd1,      1'b0, 35'd0},
		'{1'b1, REG_COLS_B,    3'd0, 3'd0, 16'd15,     1'b0, 35'd0},
		'{1'b0, CMD_START,     3'd0, 3'd0, 16'h0000,   1'b0, 35'd0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [DIM_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            cmd;
	logic [IDX_W-1:0]      row;
	logic [IDX_W-1:0]      col;
	logic signed [VAL_W-1:0] value;
	logic                  out_valid;
	logic                  out_ready;
	logic [IDX_W-1:0]      out_row;
	logic [IDX_W-1:0]      out_col;
	logic signed [SUM_W-1:0] out_value;
	logic                  last;

	logic [VAL_W-1:0] left_copy [DIM*DIM];
	logic [VAL_W-1:0] right_copy [DIM*DIM];
	bit               left_loaded [DIM*DIM];
	bit               right_loaded [DIM*DIM];
	logic [DIM_W-1:0] rows_cfg;
	logic [DIM_W-1:0] inner_cfg;
	logic [DIM_W-1:0] cols_cfg;
	elem_t            product_q [$];

	int send_idle;
	int recv_idle;
	bit hold_req = 1'b0;
	bit counting = 1'b0;
	int random_words = 0;
	int fail_count = 0;
	int cycle_count = 0;

	matrix_multiply_unit dut (
		.clk,
		.arst_n,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data,
		.in_valid,
		.in_ready,
		.cmd,
		.row,
		.col,
		.value,
		.out_valid,
		.out_ready,
		.out_row,
		.out_col,
		.out_value,
		.last
	);

	always #2 clk = ~clk;

	function automatic int used_dim(logic [DIM_W-1:0] d);
		return (d > DIM) ? DIM : int'(d);
	endfunction

	function automatic int span(int n);
		return (n == 0) ? DIM : n;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return 4'd15;
			2: return 4'd8;
			3: return DIM_W'($urandom_range(9, 14));
			default: return DIM_W'($urandom_range(1, 4));
		endcase
	endfunction

	task automatic store_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
		case (idx)
			REG_ROWS_A: rows_cfg = data;
			REG_INNER_DIM: inner_cfg = data;
			REG_COLS_B: cols_cfg = data;
			default: ;
		endcase
	endtask

	task automatic predict_product();
		int nr;
		int nk;
		int nc;
		longint acc;
		elem_t e;
		nr = used_dim(rows_cfg);
		nk = used_dim(inner_cfg);
		nc = used_dim(cols_cfg);
		if (nr != 0 && nk != 0 && nc != 0) begin
			for (int i = 0; i < nr; i++) begin
				for (int j = 0; j < nc; j++) begin
					acc = 0;
					for (int k = 0; k < nk; k++) begin
						acc += longint'($signed(left_copy[i*DIM+k]))
							* longint'($signed(right_copy[k*DIM+j]));
					end
					e.row = IDX_W'(i);
					e.col = IDX_W'(j);
					e.value = SUM_W'(acc);
					e.last = (i == nr - 1) && (j == nc - 1);
					product_q.push_back(e);
				end
			end
		end
	endtask

	task automatic predict_word(logic [1:0] c, logic [IDX_W-1:0] r, logic [IDX_W-1:0] k,
			logic [VAL_W-1:0] v);
		case (c)
			CMD_WRITE_A: begin
				left_copy[int'(r)*DIM+int'(k)] = v;
				left_loaded[int'(r)*DIM+int'(k)] = 1'b1;
			end
			CMD_WRITE_B: begin
				right_copy[int'(r)*DIM+int'(k)] = v;
				right_loaded[int'(r)*DIM+int'(k)] = 1'b1;
			end
			CMD_START: predict_product();
			default: ;
		endcase
	endtask

	task automatic set_idling(int s, int r);
		send_idle = s;
		recv_idle = r;
	endtask

	task automatic send_word(logic [1:0] c, logic [IDX_W-1:0] r, logic [IDX_W-1:0] k,
			logic [VAL_W-1:0] v, bit typed, logic [SUM_W-1:0] typed_value);
		elem_t e;
		if (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
		end
		in_valid <= 1'b1;
		cmd <= c;
		row <= r;
		col <= k;
		value <= v;
		do @(posedge clk); while (!in_ready);
		if (typed) begin
			e = '{'0, '0, typed_value, 1'b1};
			product_q.push_back(e);
		end else begin
			predict_word(c, r, k, v);
		end
		if (counting && c != CMD_UNUSED)
			random_words++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		store_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (product_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_missing();
		int nr;
		int nk;
		int nc;
		nr = used_dim(rows_cfg);
		nk = used_dim(inner_cfg);
		nc = used_dim(cols_cfg);
		if (nr != 0 && nk != 0 && nc != 0) begin
			for (int i = 0; i < nr; i++)
				for (int k = 0; k < nk; k++)
					if (!left_loaded[i*DIM+k])
						send_word(CMD_WRITE_A, IDX_W'(i), IDX_W'(k), pick_value(), 1'b0, '0);
			for (int k = 0; k < nk; k++)
				for (int j = 0; j < nc; j++)
					if (!right_loaded[k*DIM+j])
						send_word(CMD_WRITE_B, IDX_W'(k), IDX_W'(j), pick_value(), 1'b0, '0);
		end
	endtask

	task automatic load_inside(int nr, int nk, int nc);
		if ($urandom_range(0, 1)) begin
			send_word(CMD_WRITE_A, IDX_W'($urandom_range(0, span(nr) - 1)),
				IDX_W'($urandom_range(0, span(nk) - 1)), pick_value(), 1'b0, '0);
		end else begin
			send_word(CMD_WRITE_B, IDX_W'($urandom_range(0, span(nk) - 1)),
				IDX_W'($urandom_range(0, span(nc) - 1)), pick_value(), 1'b0, '0);
		end
	endtask

	task automatic run_segment(bit squeeze);
		logic [DIM_W-1:0] d [3];
		int nr;
		int nk;
		int nc;
		int pick;
		settle();
		for (int i = 0; i < 3; i++)
			d[i] = squeeze ? DIM_W'(4) : pick_dim();
		write_reg(REG_ROWS_A, d[0]);
		write_reg(REG_INNER_DIM, d[1]);
		write_reg(REG_COLS_B, d[2]);
		nr = used_dim(rows_cfg);
		nk = used_dim(inner_cfg);
		nc = used_dim(cols_cfg);
		repeat ($urandom_range(2, 10)) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				send_word(CMD_UNUSED, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom),
					1'b0, '0);
			end else if (pick < 15) begin
				send_word($urandom_range(0, 1) ? CMD_WRITE_B : CMD_WRITE_A, IDX_W'($urandom),
					IDX_W'($urandom), pick_value(), 1'b0, '0);
			end else begin
				load_inside(nr, nk, nc);
			end
		end
		load_missing();
		if (squeeze)
			hold_req = 1'b1;
		send_word(CMD_START, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom), 1'b0, '0);
		if (squeeze || $urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(0, 3))
				load_inside(nr, nk, nc);
			send_word(CMD_START, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom),
				1'b0, '0);
		end
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		elem_t want;
		if (arst_n && out_valid && out_ready) begin
			if (product_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_SHOWN)
					$display("unexpected product word: row %0d col %0d value %0d last %0b",
						out_row, out_col, out_value, last);
			end else begin
				want = product_q.pop_front();
				if (out_row !== want.row || out_col !== want.col
						|| out_value !== want.value || last !== want.last) begin
					fail_count++;
					if (fail_count <= MAX_SHOWN) begin
						$display("product word mismatch: expected row %0d col %0d value %0d last %0b",
							want.row, want.col, $signed(want.value), want.last);
						$display("  got row %0d col %0d value %0d last %0b",
							out_row, out_col, out_value, last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** matrix_multiply_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = '0;
		row = '0;
		col = '0;
		value = '0;
		rows_cfg = DIM_RESET;
		inner_cfg = DIM_RESET;
		cols_cfg = DIM_RESET;
		set_idling(24, 63);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED); i++) begin
			if (DIRECTED[i].is_reg) begin
				settle();
				write_reg(DIRECTED[i].code, DIRECTED[i].value[DIM_W-1:0]);
			end else begin
				if (DIRECTED[i].code == CMD_START && !DIRECTED[i].typed)
					load_missing();
				send_word(DIRECTED[i].code, DIRECTED[i].row, DIRECTED[i].col,
					DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].typed_value);
			end
		end

		counting = 1'b1;
		run_segment(1'b1);
		while (random_words < RANDOM_WORDS) begin
			if (random_words < RANDOM_WORDS / 3)
				set_idling(24, 63);
			else if (random_words < 2 * RANDOM_WORDS / 3)
				set_idling(63, 24);
			else
				set_idling(0, 0);
			run_segment(1'b0);
		end

		settle();
		if (fail_count == 0 && product_q.size() == 0) begin
			$display("** matrix_multiply_unit: PASSED **");
		end else begin
			$display("** matrix_multiply_unit: FAILED **");
		end
		$finish;
	end

endmodule

[matrix_multiply_unit.f]
rtl/mmu_pkg.sv
rtl/mmu_datapath.sv
rtl/matrix_multiply_unit.sv
rtl/mmu_checker.sv
tb/matrix_multiply_unit_tb.sv
